### design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

   localparam int OP_W   = 3;
   localparam int DATA_W = 32;
   localparam int DEN_W  = 31;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_NORM = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_DIVZERO  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_COMBINE,
      S_GCD_INIT,
      S_GCD_STEP,
      S_DIV_INIT,
      S_DIV_STEP,
      S_DIV_NEXT,
      S_CHECK,
      S_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // capture input item
      logic mul;       // run one multiply step
      logic combine;   // form numerator and denominator
      logic gcd_init;  // set up Euclid operands
      logic gcd_step;  // one subtract/shift step of x mod y
      logic gcd_swap;  // x<=y, y<=remainder
      logic div_init;  // start num/g
      logic div_step;  // one quotient bit
      logic div_next;  // move to den/g
      logic finish;    // form result
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic early;     // divide by zero or zero numerator, result already set
      logic y_zero;    // gcd done
      logic rem_done;  // current remainder step finished
      logic div_done;  // current quotient finished
      logic div_second;// second quotient in progress
   } stat_type;

endpackage

### design/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for the rational arithmetic unit: multiply, gcd, divide, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rau_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  logic              out_fire,
   input  rau_pkg::stat_type st,
   output rau_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              out_valid
);
   import rau_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (in_fire) state_in = S_MUL1;
         S_MUL1:     state_in = S_MUL2;
         S_MUL2:     state_in = S_MUL3;
         S_MUL3:     state_in = S_COMBINE;
         S_COMBINE:  state_in = S_GCD_INIT;
         S_GCD_INIT: begin
            if (st.early) state_in = S_OUT;
            else state_in = S_GCD_STEP;
         end
         S_GCD_STEP: begin
            if (st.y_zero) state_in = S_DIV_INIT;
         end
         S_DIV_INIT: state_in = S_DIV_STEP;
         S_DIV_STEP: begin
            if (st.div_done) begin
               if (st.div_second) state_in = S_CHECK;
               else state_in = S_DIV_NEXT;
            end
         end
         S_DIV_NEXT: state_in = S_DIV_STEP;
         S_CHECK:    state_in = S_OUT;
         S_OUT:      if (out_fire) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE:     begin
            busy     = 1'b0;
            cmd.load = in_fire;
         end
         S_MUL1, S_MUL2, S_MUL3: cmd.mul = 1'b1;
         S_COMBINE:  cmd.combine = 1'b1;
         S_GCD_INIT: cmd.gcd_init = 1'b1;
         S_GCD_STEP: begin
            if (!st.y_zero) begin
               if (st.rem_done) cmd.gcd_swap = 1'b1;
               else cmd.gcd_step = 1'b1;
            end
         end
         S_DIV_INIT: cmd.div_init = 1'b1;
         S_DIV_STEP: cmd.div_step = !st.div_done;
         S_DIV_NEXT: cmd.div_next = 1'b1;
         S_CHECK:    cmd.finish = 1'b1;
         S_OUT:      out_valid = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

   `ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_fire, out_valid, "result dropped")
   `ASSERT_IMPL(a_load_idle, clock, reset, cmd.load, !busy, "load while busy")
   `ASSERT_NEXT(a_fire_leaves, clock, reset, out_fire, state_ff == S_IDLE, "no return to idle")

endmodule

### design/rau_dpath.sv
// ----------------------------------------------------------------------------
// rau_dpath
// Datapath: operand magnitudes, shared 32x32 multiplier, shift-subtract
// remainder for Euclid, restoring divider for the reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_dpath #(
   parameter int WIDTH = 32
) (
   input  logic                        clock,
   input  rau_pkg::cmd_type            cmd,
   input  logic [rau_pkg::OP_W-1:0]    op,
   input  logic [rau_pkg::DATA_W-1:0]  a_num,
   input  logic [rau_pkg::DATA_W-1:0]  a_den,
   input  logic [rau_pkg::DATA_W-1:0]  b_num,
   input  logic [rau_pkg::DATA_W-1:0]  b_den,
   output rau_pkg::stat_type           st,
   output logic [rau_pkg::DATA_W-1:0]  res_num,
   output logic [rau_pkg::DEN_W-1:0]   res_den,
   output logic [rau_pkg::STAT_W-1:0]  status
);
   import rau_pkg::*;

   localparam int MW = 2 * WIDTH;
   localparam int CW = $clog2(MW + 1);

   logic [OP_W-1:0]  op_ff;
   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic             an_neg_ff, bn_neg_ff;
   logic [1:0]       mstep_ff;
   logic [MW-1:0]    p0_ff, p1_ff, p2_ff;
   logic             num_neg_ff;
   logic [MW:0]      num_ff;
   logic [MW-1:0]    den_ff;
   logic [MW:0]      x_ff, y_ff, r_ff, ys_ff;
   logic             up_ff;
   logic [MW:0]      q_ff, dd_ff, rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic             second_ff;
   logic [MW:0]      qnum_ff;
   logic [DATA_W-1:0] res_num_ff;
   logic [DEN_W-1:0]  res_den_ff;
   logic [STAT_W-1:0] status_ff;

   function automatic logic [WIDTH-1:0] mag_of(input logic [DATA_W-1:0] v);
      logic [WIDTH-1:0] t;
      t = v[WIDTH-1:0];
      return t[WIDTH-1] ? (~t + 1'b1) : t;
   endfunction

   // multiplier operand selection by step
   logic [WIDTH-1:0] ma, mb;
   logic [MW-1:0]    prod;
   always_comb begin
      ma = ad_ff;
      mb = bd_ff;
      unique case (mstep_ff)
         2'd0: begin
            ma = an_ff;
            mb = ((op_ff == OP_MUL) ? bn_ff : bd_ff);
         end
         2'd1: begin
            ma = ad_ff;
            mb = ((op_ff == OP_DIV) ? bn_ff : bd_ff);
         end
         2'd2: begin
            ma = bn_ff;
            mb = ad_ff;
         end
         default: begin
            ma = ad_ff;
            mb = bd_ff;
         end
      endcase
      prod = MW'(ma) * MW'(mb);
   end

   logic two_ops, is_addsub, sub_neg;
   assign two_ops   = (op_ff == OP_ADD) || (op_ff == OP_SUB) ||
                      (op_ff == OP_MUL) || (op_ff == OP_DIV);
   assign is_addsub = (op_ff == OP_ADD) || (op_ff == OP_SUB);
   assign sub_neg   = (op_ff == OP_SUB) ? !bn_neg_ff : bn_neg_ff;

   logic div_zero, num_zero;
   assign div_zero = (ad_ff == '0) || (two_ops && bd_ff == '0) ||
                     (op_ff == OP_DIV && bn_ff == '0);
   assign num_zero = (num_ff == '0);

   // remainder step: subtract shifted divisor
   logic [MW:0] r_sub;
   assign r_sub = r_ff - ys_ff;

   // divisor can still double without passing the remainder
   logic grow;
   assign grow = (ys_ff[MW] == 1'b0) && ((ys_ff << 1) <= r_ff);

   // restoring divider step
   logic [MW+1:0] trial;
   assign trial = {rem_ff, dd_ff[MW]} - {1'b0, y_ff};

   logic [MW:0]  half;
   assign half = (MW + 1)'(1) << (WIDTH - 1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op;
         an_ff     <= mag_of(a_num);
         ad_ff     <= mag_of(a_den);
         bn_ff     <= mag_of(b_num);
         bd_ff     <= mag_of(b_den);
         an_neg_ff <= a_num[WIDTH-1] ^ a_den[WIDTH-1];
         bn_neg_ff <= b_num[WIDTH-1] ^ b_den[WIDTH-1];
         mstep_ff  <= 2'd0;
      end
      if (cmd.mul) begin
         mstep_ff <= mstep_ff + 2'd1;
         unique case (mstep_ff)
            2'd0:    p0_ff <= prod;
            2'd1:    p1_ff <= prod;
            default: p2_ff <= prod;
         endcase
      end
      if (cmd.combine) begin
         status_ff <= ST_OK;
         if (is_addsub) begin
            if (an_neg_ff == sub_neg) begin
               num_neg_ff <= an_neg_ff;
               num_ff     <= {1'b0, p0_ff} + {1'b0, p2_ff};
            end else if (p0_ff >= p2_ff) begin
               num_neg_ff <= an_neg_ff;
               num_ff     <= {1'b0, p0_ff - p2_ff};
            end else begin
               num_neg_ff <= sub_neg;
               num_ff     <= {1'b0, p2_ff - p0_ff};
            end
         end else if (op_ff == OP_MUL || op_ff == OP_DIV) begin
            num_neg_ff <= an_neg_ff ^ bn_neg_ff;
            num_ff     <= {1'b0, p0_ff};
         end else begin
            num_neg_ff <= an_neg_ff;
            num_ff     <= (MW + 1)'(an_ff);
         end
      end
      if (cmd.gcd_init) begin
         den_ff <= is_addsub ? p1_ff : (two_ops ? p1_ff : MW'(ad_ff));
         x_ff   <= num_ff;
         y_ff   <= {1'b0, (is_addsub || two_ops) ? p1_ff : MW'(ad_ff)};
         r_ff   <= num_ff;
         ys_ff  <= {1'b0, (is_addsub || two_ops) ? p1_ff : MW'(ad_ff)};
         up_ff  <= 1'b1;
         res_num_ff <= '0;
         res_den_ff <= '0;
         if (div_zero) begin
            status_ff <= ST_DIVZERO;
         end else if (num_zero) begin
            res_den_ff <= DEN_W'(1);
         end
      end
      // Euclid: r = x mod y; align the divisor up first, then subtract and
      // shift back down to y
      if (cmd.gcd_step) begin
         if (up_ff) begin
            if (grow) ys_ff <= ys_ff << 1;
            else up_ff <= 1'b0;
         end else if (r_ff >= ys_ff) begin
            r_ff <= r_sub;
         end else if (ys_ff != y_ff) begin
            ys_ff <= ys_ff >> 1;
         end
      end
      if (cmd.gcd_swap) begin
         x_ff  <= y_ff;
         y_ff  <= r_ff;
         r_ff  <= y_ff;
         ys_ff <= r_ff;
         up_ff <= 1'b1;
      end
      if (cmd.div_init) begin
         // y_ff = 0, x_ff = gcd; divide num by gcd
         y_ff      <= x_ff;
         dd_ff     <= num_ff;
         rem_ff    <= '0;
         q_ff      <= '0;
         cnt_ff    <= '0;
         second_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         dd_ff  <= dd_ff << 1;
         if (!trial[MW+1]) begin
            rem_ff <= trial[MW:0];
            q_ff   <= {q_ff[MW-1:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[MW-1:0], dd_ff[MW]};
            q_ff   <= {q_ff[MW-1:0], 1'b0};
         end
      end
      if (cmd.div_next) begin
         qnum_ff   <= q_ff;
         dd_ff     <= {1'b0, den_ff};
         rem_ff    <= '0;
         q_ff      <= '0;
         cnt_ff    <= '0;
         second_ff <= 1'b1;
      end
      if (cmd.finish) begin
         if (q_ff > half - 1'b1 ||
             (num_neg_ff ? (qnum_ff > half) : (qnum_ff > half - 1'b1))) begin
            status_ff  <= ST_OVERFLOW;
            res_num_ff <= '0;
            res_den_ff <= '0;
         end else begin
            res_num_ff <= DATA_W'(num_neg_ff ? ((MW + 1)'(0) - qnum_ff) : qnum_ff);
            res_den_ff <= DEN_W'(q_ff);
         end
      end
   end

   // a remainder is done once r < y with the divisor back down at y
   assign st.early      = div_zero || num_zero;
   assign st.y_zero     = (y_ff == '0);
   assign st.rem_done   = !up_ff && (r_ff < ys_ff) && (ys_ff == y_ff);
   assign st.div_done   = (cnt_ff == CW'(MW + 1));
   assign st.div_second = second_ff;

   assign res_num = res_num_ff;
   assign res_den = res_den_ff;
   assign status  = status_ff;

endmodule

### design/rational_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Normalizes, adds, subtracts, multiplies or divides signed fractions and
// returns the gcd-reduced result with a status code.
// ----------------------------------------------------------------------------
// One item at a time. An item first forms its products in the multiply
// states on the shared 32x32 multiplier, then a Euclid gcd done by
// shift-subtract remainders (the dominant part, data dependent), then two
// restoring divisions of 2*WIDTH+1 steps each for the reduction; divide by
// zero and zero results skip the gcd. req_tready is high only when idle.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rational_arithmetic_unit_top #(
   parameter int WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // op[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // res_num[31:0], res_den[62:32], status[64:63]
   output logic [71:0]   rsp_tdata
);
   import rau_pkg::*;

   cmd_type  cmd;
   stat_type st;
   logic     busy, in_fire, out_fire;
   logic [DATA_W-1:0] res_num;
   logic [DEN_W-1:0]  res_den;
   logic [STAT_W-1:0] status;

   assign req_tready = !busy;
   assign in_fire    = req_tvalid && req_tready;
   assign out_fire   = rsp_tvalid && rsp_tready;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .out_fire  (out_fire),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .out_valid (rsp_tvalid)
   );

   rau_dpath #(.WIDTH(WIDTH)) u_dpath (
      .clock   (clock),
      .cmd     (cmd),
      .op      (req_tdata[2:0]),
      .a_num   (req_tdata[34:3]),
      .a_den   (req_tdata[66:35]),
      .b_num   (req_tdata[98:67]),
      .b_den   (req_tdata[130:99]),
      .st      (st),
      .res_num (res_num),
      .res_den (res_den),
      .status  (status)
   );

   assign rsp_tdata = {7'd0, status, res_den, res_num};

   `ASSERT_IMPL(a_err_zero, clock, reset, rsp_tvalid && status != ST_OK, rsp_tdata[62:0] == '0, "error result not zero")
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready, "input taken while result pending")

endmodule
